// ----- rtl/tcg_pkg.sv -----
// Shared types, request codes and constants of the terminal character grid.
package tcg_pkg;

    localparam int TYPE_W     = 4;
    localparam int CH_W       = 8;
    localparam int RA_W       = 8;
    localparam int CA_W       = 9;
    localparam int MODE_W     = 2;
    localparam int SGR_W      = 9;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int COLOR_W    = 4;
    localparam int FLAG_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [TYPE_W-1:0] REQ_PUT          = 4'd0;
    localparam logic [TYPE_W-1:0] REQ_LF           = 4'd1;
    localparam logic [TYPE_W-1:0] REQ_CR           = 4'd2;
    localparam logic [TYPE_W-1:0] REQ_MOVE         = 4'd3;
    localparam logic [TYPE_W-1:0] REQ_ABS          = 4'd4;
    localparam logic [TYPE_W-1:0] REQ_ERASE_LINE   = 4'd5;
    localparam logic [TYPE_W-1:0] REQ_ERASE_SCREEN = 4'd6;
    localparam logic [TYPE_W-1:0] REQ_SGR          = 4'd7;
    localparam logic [TYPE_W-1:0] REQ_RESET        = 4'd8;
    localparam logic [TYPE_W-1:0] REQ_READ         = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    localparam logic [ROW_W-1:0]   ROWS_RESET = 6'd24;
    localparam logic [COL_W-1:0]   COLS_RESET = 8'd80;
    localparam logic [COLOR_W-1:0] FG_DEFAULT = 4'd7;
    localparam logic [COLOR_W-1:0] BG_DEFAULT = 4'd0;
    localparam logic [COLOR_W-1:0] BRIGHT_OFS = 4'd8;
    localparam logic [CH_W-1:0]    CHAR_NL    = 8'd10;

    localparam logic [FLAG_W-1:0] FLAG_BOLD  = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_UNDER = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_INV   = 3'b100;

    localparam logic [MODE_W-1:0] ERASE_TO_END     = 2'd0;
    localparam logic [MODE_W-1:0] ERASE_FROM_START = 2'd1;

    localparam logic signed [SGR_W-1:0] SGR_DEFAULT_ARG = -9'sd1;
    localparam logic signed [SGR_W-1:0] SGR_RESET    = 9'sd0;
    localparam logic signed [SGR_W-1:0] SGR_BOLD     = 9'sd1;
    localparam logic signed [SGR_W-1:0] SGR_UNDER    = 9'sd4;
    localparam logic signed [SGR_W-1:0] SGR_INV      = 9'sd7;
    localparam logic signed [SGR_W-1:0] SGR_NO_BOLD  = 9'sd22;
    localparam logic signed [SGR_W-1:0] SGR_NO_UNDER = 9'sd24;
    localparam logic signed [SGR_W-1:0] SGR_NO_INV   = 9'sd27;
    localparam logic signed [SGR_W-1:0] SGR_FG_DEF   = 9'sd39;
    localparam logic signed [SGR_W-1:0] SGR_BG_DEF   = 9'sd49;
    localparam logic signed [SGR_W-1:0] SGR_FG_LO    = 9'sd30;
    localparam logic signed [SGR_W-1:0] SGR_FG_HI    = 9'sd37;
    localparam logic signed [SGR_W-1:0] SGR_BG_LO    = 9'sd40;
    localparam logic signed [SGR_W-1:0] SGR_BG_HI    = 9'sd47;
    localparam logic signed [SGR_W-1:0] SGR_FGB_LO   = 9'sd90;
    localparam logic signed [SGR_W-1:0] SGR_FGB_HI   = 9'sd97;
    localparam logic signed [SGR_W-1:0] SGR_BGB_LO   = 9'sd100;
    localparam logic signed [SGR_W-1:0] SGR_BGB_HI   = 9'sd107;

    typedef struct packed {
        logic [FLAG_W-1:0]  flags;
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CH_W-1:0]    ch;
    } tcg_cell_t;

    localparam int CELL_W = $bits(tcg_cell_t);

    typedef struct packed {
        logic accept;
        logic exec;
        logic wrap;
        logic load_range;
        logic scroll_start;
        logic scroll_rd;
        logic scroll_wr;
        logic scroll_tail;
        logic clr_step;
        logic put_wr;
        logic rd_capture;
        logic load_out;
        logic init_step;
    } tcg_cmd_t;

    typedef struct packed {
        logic char_nl;
        logic row_ge;
        logic col_ge;
        logic lf_scroll;
        logic sweep_done;
        logic init_last;
        logic out_free;
    } tcg_status_t;

endpackage

// ----- rtl/tcg_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module tcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/tcg_ctrl.sv -----
// Request sequencer of the terminal character grid.
module tcg_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tcg_pkg::TYPE_W-1:0]  s_tuser,
    input  tcg_pkg::tcg_status_t        st,
    output tcg_pkg::tcg_cmd_t           cmd
);
    import tcg_pkg::*;

    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_DECODE    = 4'd2;
    localparam logic [3:0] ST_PUT_CHECK = 4'd3;
    localparam logic [3:0] ST_PUT_WR    = 4'd4;
    localparam logic [3:0] ST_SCR_START = 4'd5;
    localparam logic [3:0] ST_SCR_RD    = 4'd6;
    localparam logic [3:0] ST_SCR_WR    = 4'd7;
    localparam logic [3:0] ST_CLR       = 4'd8;
    localparam logic [3:0] ST_RANGE     = 4'd9;
    localparam logic [3:0] ST_RD_ADDR   = 4'd10;
    localparam logic [3:0] ST_RD_DATA   = 4'd11;
    localparam logic [3:0] ST_DONE      = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic              scroll_reg, scroll_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            type_reg   <= REQ_PUT;
            scroll_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            type_reg   <= type_next;
            scroll_reg <= scroll_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        type_next   = type_reg;
        scroll_next = scroll_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_step = 1'b1;
                if (st.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    type_next  = s_tuser;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (type_reg)
                    REQ_PUT: begin
                        if (st.char_nl) begin
                            cmd.exec   = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_PUT_CHECK;
                        end
                    end
                    REQ_LF: begin
                        if (st.lf_scroll) begin
                            state_next = ST_SCR_START;
                        end else begin
                            cmd.exec   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                    REQ_CR, REQ_MOVE, REQ_ABS, REQ_SGR: begin
                        cmd.exec   = 1'b1;
                        state_next = ST_DONE;
                    end
                    REQ_ERASE_LINE, REQ_ERASE_SCREEN, REQ_RESET: begin
                        state_next = ST_RANGE;
                    end
                    REQ_READ: begin
                        state_next = ST_RD_ADDR;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PUT_CHECK: begin
                priority if (st.row_ge) begin
                    state_next = ST_SCR_START;
                end else if (st.col_ge) begin
                    cmd.wrap = 1'b1;
                end else begin
                    state_next = ST_PUT_WR;
                end
            end
            ST_PUT_WR: begin
                cmd.put_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_SCR_START: begin
                cmd.scroll_start = 1'b1;
                scroll_next      = 1'b1;
                state_next       = ST_SCR_RD;
            end
            ST_SCR_RD: begin
                if (st.sweep_done) begin
                    cmd.scroll_tail = 1'b1;
                    state_next      = ST_CLR;
                end else begin
                    cmd.scroll_rd = 1'b1;
                    state_next    = ST_SCR_WR;
                end
            end
            ST_SCR_WR: begin
                cmd.scroll_wr = 1'b1;
                state_next    = ST_SCR_RD;
            end
            ST_RANGE: begin
                cmd.load_range = 1'b1;
                cmd.exec       = 1'b1;
                state_next     = ST_CLR;
            end
            ST_CLR: begin
                if (st.sweep_done) begin
                    scroll_next = 1'b0;
                    if (scroll_reg && type_reg == REQ_PUT) begin
                        state_next = ST_PUT_CHECK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cmd.clr_step = 1'b1;
                end
            end
            ST_RD_ADDR: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/tcg_datapath.sv -----
// Cursor, attributes, size registers, cell sweeps and result register of the grid.
module tcg_datapath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tcg_pkg::tcg_cmd_t               cmd,
    output tcg_pkg::tcg_status_t            st,
    input  logic [tcg_pkg::TYPE_W-1:0]      s_tuser,
    input  logic [tcg_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcg_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tcg_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = ADDR_W + 2;

    function automatic logic [ROW_W-1:0] clamp_row(input logic signed [RA_W+1:0] v,
                                                   input logic [ROW_W-1:0] hi);
        logic [ROW_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({4'b0, hi})) begin
            r = hi;
        end else begin
            r = v[ROW_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic signed [CA_W+1:0] v,
                                                   input logic [COL_W-1:0] hi);
        logic [COL_W-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v > $signed({3'b0, hi})) begin
            c = hi;
        end else begin
            c = v[COL_W-1:0];
        end
        return c;
    endfunction

    logic [ROW_W-1:0]   rows_cfg_reg;
    logic [COL_W-1:0]   cols_cfg_reg;
    logic [ROW_W-1:0]   rows_eff, rows_m1;
    logic [COL_W-1:0]   cols_eff, cols_m1;

    logic [TYPE_W-1:0]        type_reg;
    logic [CH_W-1:0]          ch_reg;
    logic [RA_W-1:0]          ra_reg;
    logic [CA_W-1:0]          ca_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [SGR_W-1:0]  sgr_reg;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COLOR_W-1:0] fg_reg, fg_next, bg_reg, bg_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;

    logic [CNT_W-1:0] prod_cur_reg, prod_line_reg, prod_rd_reg, total_reg, tail_reg;
    logic [CNT_W-1:0] ptr_reg, end_reg;
    logic [CNT_W-1:0] cur_lin, cur_cap, range_start, range_end, scr_src, rd_lin;

    logic signed [RA_W+1:0] ra_ext, row_rel;
    logic signed [CA_W+1:0] ca_ext, col_rel;
    logic [ROW_W-1:0]       abs_row, line_row;
    logic [COL_W-1:0]       abs_col;
    logic [ROW_W:0]         row_inc;
    logic [COL_W:0]         from_col, to_col, col9, cols9;
    logic signed [SGR_W-1:0] sgr_v;

    logic              sc_reg;
    tcg_cell_t         cell_reg, put_cell, rd_cell;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROWS: rows_cfg_reg <= cfg_data[ROW_W-1:0];
                CFG_COLS: cols_cfg_reg <= cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (rows_cfg_reg == '0) begin
            rows_eff = ROW_W'(1);
        end else if (int'(rows_cfg_reg) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_cfg_reg;
        end
        priority if (cols_cfg_reg == '0) begin
            cols_eff = COL_W'(1);
        end else if (int'(cols_cfg_reg) > MAX_COLS) begin
            cols_eff = COL_W'(MAX_COLS);
        end else begin
            cols_eff = cols_cfg_reg;
        end
    end

    assign rows_m1 = rows_eff - ROW_W'(1);
    assign cols_m1 = cols_eff - COL_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            type_reg <= s_tuser;
            ch_reg   <= s_tdata[7:0];
            ra_reg   <= s_tdata[15:8];
            ca_reg   <= s_tdata[24:16];
            mode_reg <= s_tdata[26:25];
            sgr_reg  <= s_tdata[35:27];
        end
    end

    assign ra_ext   = {{2{ra_reg[RA_W-1]}}, ra_reg};
    assign ca_ext   = {{2{ca_reg[CA_W-1]}}, ca_reg};
    assign row_rel  = $signed({4'b0, row_reg}) + ra_ext;
    assign col_rel  = $signed({3'b0, col_reg}) + ca_ext;
    assign abs_row  = clamp_row(ra_ext, rows_m1);
    assign abs_col  = clamp_col(ca_ext, cols_m1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);

    assign st.char_nl    = (ch_reg == CHAR_NL);
    assign st.row_ge     = (row_reg >= rows_eff);
    assign st.col_ge     = (col_reg >= cols_eff);
    assign st.lf_scroll  = (row_inc >= {1'b0, rows_eff});
    assign st.sweep_done = (ptr_reg >= end_reg);
    assign st.init_last  = (ptr_reg == CNT_W'(DEPTH - 1));
    assign st.out_free   = !m_tvalid_reg || m_tready;

    assign line_row = st.row_ge ? rows_m1 : row_reg;

    always_ff @(posedge aclk) begin
        prod_cur_reg  <= CNT_W'(row_reg) * CNT_W'(cols_eff);
        prod_line_reg <= CNT_W'(line_row) * CNT_W'(cols_eff);
        prod_rd_reg   <= CNT_W'(abs_row) * CNT_W'(cols_eff);
        total_reg     <= CNT_W'(rows_eff) * CNT_W'(cols_eff);
        tail_reg      <= CNT_W'(rows_m1) * CNT_W'(cols_eff);
    end

    assign cur_lin = prod_cur_reg + CNT_W'(col_reg);
    assign cur_cap = (cur_lin > total_reg) ? total_reg : cur_lin;
    assign col9    = {1'b0, col_reg};
    assign cols9   = {1'b0, cols_eff};

    always_comb begin
        from_col = '0;
        to_col   = cols9;
        priority if (mode_reg == ERASE_TO_END) begin
            from_col = (col9 > cols9) ? cols9 : col9;
        end else if (mode_reg == ERASE_FROM_START) begin
            to_col = (col9 + (COL_W+1)'(1) > cols9) ? cols9 : col9 + (COL_W+1)'(1);
        end else begin
            to_col = cols9;
        end
    end

    always_comb begin
        range_start = '0;
        range_end   = total_reg;
        unique case (type_reg)
            REQ_ERASE_LINE: begin
                range_start = prod_line_reg + CNT_W'(from_col);
                range_end   = prod_line_reg + CNT_W'(to_col);
            end
            REQ_ERASE_SCREEN: begin
                priority if (mode_reg == ERASE_TO_END) begin
                    range_start = cur_cap;
                end else if (mode_reg == ERASE_FROM_START) begin
                    range_end = (cur_cap < total_reg) ? cur_cap + CNT_W'(1) : total_reg;
                end else begin
                    range_end = total_reg;
                end
            end
            default: ;
        endcase
    end

    assign sgr_v = (sgr_reg == SGR_DEFAULT_ARG) ? SGR_RESET : sgr_reg;

    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        flags_next = flags_reg;
        if (cmd.exec) begin
            unique case (type_reg)
                REQ_PUT: begin
                    row_next = (row_inc < {1'b0, rows_eff}) ? row_inc[ROW_W-1:0] : rows_eff;
                    col_next = '0;
                end
                REQ_LF: row_next = row_inc[ROW_W-1:0];
                REQ_CR: col_next = '0;
                REQ_MOVE: begin
                    row_next = clamp_row(row_rel, rows_m1);
                    col_next = clamp_col(col_rel, cols_m1);
                end
                REQ_ABS: begin
                    row_next = abs_row;
                    col_next = abs_col;
                end
                REQ_ERASE_SCREEN: begin
                    if (mode_reg[1]) begin
                        row_next = '0;
                        col_next = '0;
                    end
                end
                REQ_SGR: begin
                    priority if (sgr_v >= SGR_FG_LO && sgr_v <= SGR_FG_HI) begin
                        fg_next = sgr_v[COLOR_W-1:0] - SGR_FG_LO[COLOR_W-1:0];
                    end else if (sgr_v >= SGR_BG_LO && sgr_v <= SGR_BG_HI) begin
                        bg_next = sgr_v[COLOR_W-1:0] - SGR_BG_LO[COLOR_W-1:0];
                    end else if (sgr_v >= SGR_FGB_LO && sgr_v <= SGR_FGB_HI) begin
                        fg_next = sgr_v[COLOR_W-1:0] - SGR_FGB_LO[COLOR_W-1:0] + BRIGHT_OFS;
                    end else if (sgr_v >= SGR_BGB_LO && sgr_v <= SGR_BGB_HI) begin
                        bg_next = sgr_v[COLOR_W-1:0] - SGR_BGB_LO[COLOR_W-1:0] + BRIGHT_OFS;
                    end else begin
                        unique case (sgr_v)
                            SGR_RESET: begin
                                fg_next    = FG_DEFAULT;
                                bg_next    = BG_DEFAULT;
                                flags_next = '0;
                            end
                            SGR_BOLD:     flags_next = flags_reg | FLAG_BOLD;
                            SGR_UNDER:    flags_next = flags_reg | FLAG_UNDER;
                            SGR_INV:      flags_next = flags_reg | FLAG_INV;
                            SGR_NO_BOLD:  flags_next = flags_reg & ~FLAG_BOLD;
                            SGR_NO_UNDER: flags_next = flags_reg & ~FLAG_UNDER;
                            SGR_NO_INV:   flags_next = flags_reg & ~FLAG_INV;
                            SGR_FG_DEF:   fg_next = FG_DEFAULT;
                            SGR_BG_DEF:   bg_next = BG_DEFAULT;
                            default: ;
                        endcase
                    end
                end
                REQ_RESET: begin
                    row_next   = '0;
                    col_next   = '0;
                    fg_next    = FG_DEFAULT;
                    bg_next    = BG_DEFAULT;
                    flags_next = '0;
                end
                default: ;
            endcase
        end
        if (cmd.wrap) begin
            row_next = row_inc[ROW_W-1:0];
            col_next = '0;
        end
        if (cmd.scroll_start) begin
            row_next = rows_m1;
        end
        if (cmd.put_wr) begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            fg_reg    <= FG_DEFAULT;
            bg_reg    <= BG_DEFAULT;
            flags_reg <= '0;
        end else begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            end_reg <= '0;
        end else begin
            priority if (cmd.load_range) begin
                ptr_reg <= range_start;
                end_reg <= range_end;
            end else if (cmd.scroll_start) begin
                ptr_reg <= '0;
                end_reg <= tail_reg;
            end else if (cmd.scroll_tail) begin
                end_reg <= total_reg;
            end else if (cmd.scroll_wr || cmd.clr_step || cmd.init_step) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        put_cell.ch    = ch_reg;
        put_cell.flags = flags_reg;
        if ((flags_reg & FLAG_INV) != '0) begin
            put_cell.fg = bg_reg;
            put_cell.bg = fg_reg;
        end else begin
            put_cell.fg = fg_reg;
            put_cell.bg = bg_reg;
        end
    end

    assign scr_src   = ptr_reg + CNT_W'(cols_eff);
    assign rd_lin    = prod_rd_reg + CNT_W'(abs_col);
    assign ram_we    = cmd.clr_step || cmd.init_step || cmd.scroll_wr || cmd.put_wr;
    assign ram_waddr = cmd.put_wr ? cur_lin[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.scroll_wr ? ram_rdata : (cmd.put_wr ? put_cell : '0);
    assign ram_raddr = cmd.scroll_rd ? scr_src[ADDR_W-1:0] : rd_lin[ADDR_W-1:0];
    assign rd_cell   = ram_rdata;

    tcg_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sc_reg   <= 1'b0;
            cell_reg <= '0;
        end else begin
            if (cmd.scroll_start) begin
                sc_reg <= 1'b1;
            end
            if (cmd.rd_capture) begin
                cell_reg <= rd_cell;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {6'b0, sc_reg, cell_reg.flags, cell_reg.bg, cell_reg.fg,
                            cell_reg.ch, col_reg, row_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ----- rtl/terminal_character_grid_top.sv -----
// Terminal character grid: cell store, cursor and attributes driven by a request stream.
// One request gives one result. Erases and full reset clear their cells one at a time;
// a scroll moves each cell with one read and one write of the cell RAM and then
// clears the last row, and a character write or line feed that scrolls includes
// that scroll. After reset the whole cell RAM is cleared before the first request
// is taken; size writes are taken at any time. A result waits in an output register
// while the next request comes in.
module terminal_character_grid_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code[7:0], row_arg[15:8], col_arg[24:16], erase_mode[26:25], sgr_value[35:27]
    input  logic [tcg_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[3:0]
    input  logic [tcg_pkg::TYPE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_row_out[5:0], cursor_col_out[13:6], cell_char[21:14], cell_fg[25:22],
    // cell_bg[29:26], cell_flags[32:30], scrolled[33]
    output logic [tcg_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcg_pkg::*;

    tcg_cmd_t    cmd;
    tcg_status_t st;

    tcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    tcg_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in progress");

    a_put_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put_wr |-> !st.row_ge && !st.col_ge)
        else $error("character written outside the grid");

    a_no_request_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_wr || cmd.clr_step || cmd.init_step |-> !s_tready)
        else $error("request port open during a cell sweep");
`endif
endmodule
